FILE: rtl/typed_index_key_comparator_assert.svh
`ifndef TYPED_INDEX_KEY_COMPARATOR_ASSERT_SVH
`define TYPED_INDEX_KEY_COMPARATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define TIKC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TIKC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TIKC_ASSERT_IMPL(label, ante, cons)
`define TIKC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/tikc_pkg.sv
package tikc_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned KindW = 4;
  localparam int unsigned CountW = 4;

  typedef logic [1:0] order_t;
  localparam order_t OrdEq = 2'b00;
  localparam order_t OrdGt = 2'b01;
  localparam order_t OrdLt = 2'b11;

  localparam logic [KindW-1:0] KindI8 = 4'd0;
  localparam logic [KindW-1:0] KindU8 = 4'd1;
  localparam logic [KindW-1:0] KindI16 = 4'd2;
  localparam logic [KindW-1:0] KindU16 = 4'd3;
  localparam logic [KindW-1:0] KindI32 = 4'd4;
  localparam logic [KindW-1:0] KindU32 = 4'd5;
  localparam logic [KindW-1:0] KindI64 = 4'd6;
  localparam logic [KindW-1:0] KindU64 = 4'd7;
  localparam logic [KindW-1:0] KindF32 = 4'd8;
  localparam logic [KindW-1:0] KindF64 = 4'd9;
  localparam logic [KindW-1:0] KindBool = 4'd10;
  localparam logic [KindW-1:0] KindDate = 4'd11;
  localparam logic [KindW-1:0] KindStr20 = 4'd12;
  localparam logic [KindW-1:0] KindStr50 = 4'd13;
  localparam logic [KindW-1:0] KindStr100 = 4'd14;

  localparam int unsigned Str20Len = 20;
  localparam int unsigned Str50Len = 50;
  localparam int unsigned Str100Len = 100;
  localparam logic [KindW-1:0] KindReset = KindI8;
endpackage

FILE: rtl/tikc_word_cmp.sv
module tikc_word_cmp (
  input  logic [tikc_pkg::KindW-1:0]  kind,
  input  logic [tikc_pkg::CountW-1:0] idx,
  input  logic [tikc_pkg::WordW-1:0]  a,
  input  logic [tikc_pkg::WordW-1:0]  b,
  output tikc_pkg::order_t            res
);
  logic [63:0] ka, kb;
  logic        na, nb, nan_case, skip;
  logic [6:0]  start, lim;
  logic [6:0]  nleft;
  logic [63:0] smask;

  function automatic logic [63:0] fkey(input logic [63:0] x, input logic is32);
    logic [63:0] y;
    y = x;
    if (is32) begin
      if (y[30:0] == '0) y = '0;
      fkey = y[31] ? {32'd0, ~y[31:0]} : {32'd0, y[31:0] | 32'h8000_0000};
    end else begin
      if (y[62:0] == '0) y = '0;
      fkey = y[63] ? ~y : (y | 64'h8000_0000_0000_0000);
    end
  endfunction

  always_comb begin
    ka = a;
    kb = b;
    na = 1'b0;
    nb = 1'b0;
    nan_case = 1'b0;
    skip = (idx != '0);
    lim = 7'(tikc_pkg::Str100Len);
    start = {idx, 3'b000};
    nleft = 7'd0;
    smask = '1;
    unique case (kind)
      tikc_pkg::KindI8:  begin ka = {56'd0, ~a[7], a[6:0]};   kb = {56'd0, ~b[7], b[6:0]}; end
      tikc_pkg::KindU8:  begin ka = {56'd0, a[7:0]};  kb = {56'd0, b[7:0]}; end
      tikc_pkg::KindI16: begin ka = {48'd0, ~a[15], a[14:0]}; kb = {48'd0, ~b[15], b[14:0]}; end
      tikc_pkg::KindU16: begin ka = {48'd0, a[15:0]}; kb = {48'd0, b[15:0]}; end
      tikc_pkg::KindI32: begin ka = {32'd0, ~a[31], a[30:0]}; kb = {32'd0, ~b[31], b[30:0]}; end
      tikc_pkg::KindU32: begin ka = {32'd0, a[31:0]}; kb = {32'd0, b[31:0]}; end
      tikc_pkg::KindI64: begin ka = {~a[63], a[62:0]}; kb = {~b[63], b[62:0]}; end
      tikc_pkg::KindU64: ;
      tikc_pkg::KindF32: begin
        na = (a[30:23] == '1) && (a[22:0] != '0);
        nb = (b[30:23] == '1) && (b[22:0] != '0);
        nan_case = na | nb;
        ka = fkey({32'd0, a[31:0]}, 1'b1);
        kb = fkey({32'd0, b[31:0]}, 1'b1);
      end
      tikc_pkg::KindF64: begin
        na = (a[62:52] == '1) && (a[51:0] != '0);
        nb = (b[62:52] == '1) && (b[51:0] != '0);
        nan_case = na | nb;
        ka = fkey(a, 1'b0);
        kb = fkey(b, 1'b0);
      end
      tikc_pkg::KindBool: begin ka = {63'd0, |a}; kb = {63'd0, |b}; end
      tikc_pkg::KindDate: begin
        skip = (idx > 4'd1);
        if (idx == '0) begin
          ka = {~a[63], a[62:0]};
          kb = {~b[63], b[62:0]};
        end else begin
          ka = {32'd0, a[31:0]};
          kb = {32'd0, b[31:0]};
        end
      end
      default: begin
        if (kind == tikc_pkg::KindStr20) lim = 7'(tikc_pkg::Str20Len);
        else if (kind == tikc_pkg::KindStr50) lim = 7'(tikc_pkg::Str50Len);
        skip = (start >= lim);
        nleft = lim - start;
        if (nleft < 7'd8) smask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {nleft[2:0], 3'b000});
        ka = a & smask;
        kb = b & smask;
      end
    endcase
    if (skip) res = tikc_pkg::OrdEq;
    else if (nan_case) res = (na && nb) ? tikc_pkg::OrdEq : (na ? tikc_pkg::OrdGt : tikc_pkg::OrdLt);
    else if (ka < kb) res = tikc_pkg::OrdLt;
    else if (ka > kb) res = tikc_pkg::OrdGt;
    else res = tikc_pkg::OrdEq;
  end
endmodule

FILE: rtl/typed_index_key_comparator.sv
// Channel  Direction  Payload
// in_      input      tdata = left_word, right_word; tlast = final_word
// out_     output     tdata = order (2 bits, signed)
// cfg_     input      key_kind (4 bits)
// Each word is compared as it is taken and merged into the running order,
// and the result word appears in the cycle after the last word is taken.
// Reset clears the kind to int8 and the running state to equal.
// A new word is accepted each cycle while the output register is empty or drained.
`include "typed_index_key_comparator_assert.svh"
module typed_index_key_comparator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // left_word [63:0], right_word [127:64]
  input  logic         in_tlast,  // final_word
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata  // order [1:0], zeros above
);
  logic [tikc_pkg::KindW-1:0]  kind_r;
  tikc_pkg::order_t            run_r, run_nxt, cmp;
  logic [tikc_pkg::CountW-1:0] cnt_r, cnt_nxt;
  tikc_pkg::order_t            res_r, merged;
  logic                        vld_r, take;

  tikc_word_cmp u_cmp (
    .kind(kind_r), .idx(cnt_r), .a(in_tdata[63:0]), .b(in_tdata[127:64]), .res(cmp)
  );

  assign in_tready = !vld_r || out_tready;
  assign take      = in_tvalid && in_tready;
  assign merged    = (run_r == tikc_pkg::OrdEq) ? cmp : run_r;

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    if (take) begin
      if (in_tlast) begin
        run_nxt = tikc_pkg::OrdEq;
        cnt_nxt = '0;
      end else begin
        run_nxt = merged;
        cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= tikc_pkg::KindReset;
      run_r  <= tikc_pkg::OrdEq;
      cnt_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) kind_r <= cfg_wr_data;
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      if (take && in_tlast) vld_r <= 1'b1;
      else if (out_tready) vld_r <= 1'b0;
    end
    if (take && in_tlast) res_r <= merged;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {6'd0, res_r};

  `TIKC_ASSERT_NEXT(a_last_gives_result, take && in_tlast, out_tvalid)
  `TIKC_ASSERT_NEXT(a_last_clears_count, take && in_tlast, cnt_r == '0)
  `TIKC_ASSERT_IMPL(a_result_code, out_tvalid, res_r != 2'b10)
endmodule
